FILE: hdl/mtm_pkg.sv
// shared types and constants for the message tag matching engine
package mtm_pkg;
  localparam int QueueDepth = 16;

  localparam logic       CMD_SEND    = 1'b0;
  localparam logic       CMD_RECV    = 1'b1;
  localparam logic [1:0] OUT_MATCHED = 2'd0;
  localparam logic [1:0] OUT_QUEUED  = 2'd1;
  localparam logic [1:0] OUT_FULL    = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;
  localparam logic [1:0] MODE_IMM    = 2'd0;

  typedef struct packed {
    logic        command;
    logic [7:0]  source;
    logic        any_source;
    logic [15:0] tag;
    logic        any_tag;
    logic [7:0]  communicator;
    logic [15:0] length_bytes;
    logic [1:0]  send_mode;
    logic [7:0]  request_handle;
  } req_t;

  // one stored entry, used by both stores (flags unused for sends, mode for receives)
  typedef struct packed {
    logic [7:0]  source;
    logic        any_source;
    logic [15:0] tag;
    logic        any_tag;
    logic [7:0]  communicator;
    logic [15:0] length_bytes;
    logic [1:0]  mode;
    logic [7:0]  handle;
  } entry_t;
endpackage

FILE: hdl/mtm_front.sv
// front end: takes commands, cleans up fields, and feeds a short queue
module mtm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mtm_pkg::req_t req,
  output logic          q_valid,
  output mtm_pkg::req_t q_req,
  input  logic          q_pop
);
  mtm_pkg::req_t slot [2];
  logic [1:0] fill;
  logic       rd_ptr, wr_ptr;
  logic       push;
  mtm_pkg::req_t clean;

  always_comb begin
    clean = req;
    if (req.command == mtm_pkg::CMD_SEND) begin
      clean.any_source = 1'b0;
      clean.any_tag    = 1'b0;
      if (req.send_mode == mtm_pkg::MODE_NONE) clean.send_mode = mtm_pkg::MODE_IMM;
    end
  end

  assign busy    = fill[1];
  assign push    = start && !busy;
  assign q_valid = fill != 2'd0;
  assign q_req   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= clean;
    if (rst) begin
      fill <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

FILE: hdl/mtm_back.sv
// back end: sequential search of one store, removal by shifting, append
module mtm_back #(
  parameter int QUEUE_DEPTH = mtm_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mtm_pkg::req_t q_req,
  output logic          q_pop,
  output logic          done,
  output logic [1:0]    outcome,
  output logic [7:0]    matched_handle,
  output logic [7:0]    matched_source,
  output logic [15:0]   matched_tag,
  output logic [15:0]   copy_length,
  output logic          overflow,
  output logic [1:0]    matched_mode
);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  mtm_pkg::entry_t pmem [QUEUE_DEPTH];
  mtm_pkg::entry_t umem [QUEUE_DEPTH];
  logic [CW-1:0] pcount, ucount;
  logic [1:0]    state;
  mtm_pkg::req_t cur;
  logic [CW-1:0] idx;
  mtm_pkg::entry_t rd;
  logic [CW-1:0] cnt;
  logic hit;

  assign cnt = cur.command ? ucount : pcount;

  always_comb begin
    if (cur.command == mtm_pkg::CMD_RECV)
      hit = (cur.any_source || cur.source == rd.source) &&
            (cur.any_tag || cur.tag == rd.tag) && cur.communicator == rd.communicator;
    else
      hit = (rd.any_source || rd.source == cur.source) &&
            (rd.any_tag || rd.tag == cur.tag) && rd.communicator == cur.communicator;
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    // registered read port for the search
    rd   <= cur.command ? umem[idx[IW-1:0]] : pmem[idx[IW-1:0]];
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      pcount <= '0;
      ucount <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_req;
            idx <= '0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (idx < cnt && hit) begin
            done <= 1'b1;
            outcome <= mtm_pkg::OUT_MATCHED;
            matched_handle <= rd.handle;
            if (cur.command == mtm_pkg::CMD_SEND) begin
              matched_source <= cur.source;
              matched_tag    <= cur.tag;
              matched_mode   <= mtm_pkg::MODE_NONE;
              copy_length <= (cur.length_bytes < rd.length_bytes) ?
                             cur.length_bytes : rd.length_bytes;
              overflow <= rd.length_bytes < cur.length_bytes;
            end else begin
              matched_source <= rd.source;
              matched_tag    <= rd.tag;
              matched_mode   <= rd.mode;
              copy_length <= (rd.length_bytes < cur.length_bytes) ?
                             rd.length_bytes : cur.length_bytes;
              overflow <= cur.length_bytes < rd.length_bytes;
            end
            state <= S_SHIFT;
          end else if (idx < cnt) begin
            idx <= idx + 1'b1;
            state <= S_READ;
          end else begin
            done <= 1'b1;
            matched_handle <= '0;
            matched_source <= '0;
            matched_tag    <= '0;
            copy_length    <= '0;
            overflow       <= 1'b0;
            matched_mode   <= mtm_pkg::MODE_NONE;
            // a miss goes to the other store, or gives OUT_FULL when that store is full
            if (cur.command == mtm_pkg::CMD_SEND) begin
              if (ucount >= DEPTH_C) outcome <= mtm_pkg::OUT_FULL;
              else begin
                outcome <= mtm_pkg::OUT_QUEUED;
                umem[ucount[IW-1:0]] <= '{cur.source, 1'b0, cur.tag, 1'b0,
                  cur.communicator, cur.length_bytes, cur.send_mode, cur.request_handle};
                ucount <= ucount + 1'b1;
              end
            end else begin
              if (pcount >= DEPTH_C) outcome <= mtm_pkg::OUT_FULL;
              else begin
                outcome <= mtm_pkg::OUT_QUEUED;
                pmem[pcount[IW-1:0]] <= '{cur.source, cur.any_source, cur.tag,
                  cur.any_tag, cur.communicator, cur.length_bytes,
                  mtm_pkg::MODE_NONE, cur.request_handle};
                pcount <= pcount + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        S_SHIFT: begin
          // close the gap one entry per cycle
          if (idx + 1'b1 >= cnt) begin
            if (cur.command) ucount <= ucount - 1'b1;
            else pcount <= pcount - 1'b1;
            state <= S_IDLE;
          end else begin
            if (cur.command) umem[idx[IW-1:0]] <= umem[IW'(idx + 1'b1)];
            else pmem[idx[IW-1:0]] <= pmem[IW'(idx + 1'b1)];
            idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/message_tag_matching_engine.sv
// top level of the message tag matching engine
// a command waits in the front queue, then the back end reads and checks each stored entry
// in turn (every entry on a miss) before the registered done strobe
// a match then moves each later entry down by one place, closing the gap in the store
// one command at a time in the back end; it takes the next only once back in idle
// two commands can wait in the front queue; busy is high while it is full
// rst is synchronous and empties both stores and the queue; results cannot be stalled
module message_tag_matching_engine #(
  parameter int QUEUE_DEPTH = mtm_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [7:0]  source,
  input  logic        any_source,
  input  logic [15:0] tag,
  input  logic        any_tag,
  input  logic [7:0]  communicator,
  input  logic [15:0] length_bytes,
  input  logic [1:0]  send_mode,
  input  logic [7:0]  request_handle,
  output logic        done,
  output logic [1:0]  outcome,
  output logic [7:0]  matched_handle,
  output logic [7:0]  matched_source,
  output logic [15:0] matched_tag,
  output logic [15:0] copy_length,
  output logic        overflow,
  output logic [1:0]  matched_mode
);
  mtm_pkg::req_t req, q_req;
  logic q_valid, q_pop;

  assign req = '{command, source, any_source, tag, any_tag, communicator,
                 length_bytes, send_mode, request_handle};

  mtm_front u_front (
    .clk, .rst, .start, .busy, .req, .q_valid, .q_req, .q_pop
  );

  mtm_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_req, .q_pop, .done, .outcome, .matched_handle,
    .matched_source, .matched_tag, .copy_length, .overflow, .matched_mode
  );
endmodule

FILE: hdl/mtm_checker.sv
// port level checks for the message tag matching engine
module mtm_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [1:0]  outcome,
  input logic [7:0]  matched_handle,
  input logic [15:0] copy_length,
  input logic        overflow,
  input logic [1:0]  matched_mode
);
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> outcome == mtm_pkg::OUT_MATCHED || outcome == mtm_pkg::OUT_QUEUED
      || outcome == mtm_pkg::OUT_FULL) else $error("bad outcome");
  a_nomatch: assert property (@(posedge clk) disable iff (rst)
    done && outcome != mtm_pkg::OUT_MATCHED |-> matched_handle == 8'd0
      && copy_length == 16'd0 && !overflow && matched_mode == mtm_pkg::MODE_NONE)
    else $error("fields not cleared");
  a_reset: assert property (@(posedge clk) rst |=> !done) else $error("strobe after reset");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back to back strobes");
endmodule

bind message_tag_matching_engine mtm_port_checks u_chk (
  .clk, .rst, .done, .outcome, .matched_handle, .copy_length, .overflow, .matched_mode
);

FILE: tb/sv/mtm_checker.sv
// checker for the message tag matching engine: predicts each result and compares it
`timescale 1ns / 1ps
module mtm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [7:0]  source,
  input  logic        any_source,
  input  logic [15:0] tag,
  input  logic        any_tag,
  input  logic [7:0]  communicator,
  input  logic [15:0] length_bytes,
  input  logic [1:0]  send_mode,
  input  logic [7:0]  request_handle,
  input  logic        done,
  input  logic [1:0]  outcome,
  input  logic [7:0]  matched_handle,
  input  logic [7:0]  matched_source,
  input  logic [15:0] matched_tag,
  input  logic [15:0] copy_length,
  input  logic        overflow,
  input  logic [1:0]  matched_mode,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [1:0]  outcome;
    logic [7:0]  handle;
    logic [7:0]  source;
    logic [15:0] tag;
    logic [15:0] copy;
    logic        overflow;
    logic [1:0]  mode;
  } match_res_t;

  mtm_pkg::entry_t posted_q[$];
  mtm_pkg::entry_t unexp_q[$];
  match_res_t      expected_q[$];

  function automatic match_res_t make_res(logic [1:0] oc, logic [7:0] h, logic [7:0] s,
                                          logic [15:0] t, logic [15:0] msg,
                                          logic [15:0] buff, logic [1:0] m);
    match_res_t r;
    r.outcome  = oc;
    r.handle   = h;
    r.source   = s;
    r.tag      = t;
    r.copy     = (msg < buff) ? msg : buff;
    r.overflow = buff < msg;
    r.mode     = m;
    return r;
  endfunction

  task automatic match_request();
    mtm_pkg::entry_t e;
    bit found;
    found = 0;
    if (command == mtm_pkg::CMD_SEND) begin
      for (int i = 0; i < posted_q.size() && !found; i++) begin
        e = posted_q[i];
        if ((e.any_source || e.source == source) && (e.any_tag || e.tag == tag)
            && e.communicator == communicator) begin
          posted_q.delete(i);
          expected_q.push_back(make_res(mtm_pkg::OUT_MATCHED, e.handle, source, tag,
                                        length_bytes, e.length_bytes, mtm_pkg::MODE_NONE));
          found = 1;
        end
      end
      if (!found) begin
        if (unexp_q.size() >= mtm_pkg::QueueDepth)
          expected_q.push_back(make_res(mtm_pkg::OUT_FULL, '0, '0, '0, '0, '0,
                                        mtm_pkg::MODE_NONE));
        else begin
          e = '0;
          e.source = source; e.tag = tag; e.communicator = communicator;
          e.length_bytes = length_bytes; e.handle = request_handle;
          e.mode = (send_mode == mtm_pkg::MODE_NONE) ? mtm_pkg::MODE_IMM : send_mode;
          unexp_q.push_back(e);
          expected_q.push_back(make_res(mtm_pkg::OUT_QUEUED, '0, '0, '0, '0, '0,
                                        mtm_pkg::MODE_NONE));
        end
      end
    end else begin
      for (int i = 0; i < unexp_q.size() && !found; i++) begin
        e = unexp_q[i];
        if ((any_source || e.source == source) && (any_tag || e.tag == tag)
            && e.communicator == communicator) begin
          unexp_q.delete(i);
          expected_q.push_back(make_res(mtm_pkg::OUT_MATCHED, e.handle, e.source, e.tag,
                                        e.length_bytes, length_bytes, e.mode));
          found = 1;
        end
      end
      if (!found) begin
        if (posted_q.size() >= mtm_pkg::QueueDepth)
          expected_q.push_back(make_res(mtm_pkg::OUT_FULL, '0, '0, '0, '0, '0,
                                        mtm_pkg::MODE_NONE));
        else begin
          e = '0;
          e.source = source; e.any_source = any_source; e.tag = tag;
          e.any_tag = any_tag; e.communicator = communicator;
          e.length_bytes = length_bytes; e.handle = request_handle;
          posted_q.push_back(e);
          expected_q.push_back(make_res(mtm_pkg::OUT_QUEUED, '0, '0, '0, '0, '0,
                                        mtm_pkg::MODE_NONE));
        end
      end
    end
  endtask

  initial fail_count = 0;
  assign pending = expected_q.size();

  always @(posedge clk) begin
    match_res_t x;
    if (rst) begin
      posted_q.delete(); unexp_q.delete(); expected_q.delete();
    end else begin
      // result beat first: a beat accepted now cannot be the one a result answers
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          x = expected_q.pop_front();
          if (outcome !== x.outcome) begin
            $error("outcome exp %0d got %0d", x.outcome, outcome); fail_count++;
          end
          if (matched_handle !== x.handle) begin
            $error("matched_handle exp %0d got %0d", x.handle, matched_handle);
            fail_count++;
          end
          if (matched_source !== x.source) begin
            $error("matched_source exp %0d got %0d", x.source, matched_source);
            fail_count++;
          end
          if (matched_tag !== x.tag) begin
            $error("matched_tag exp %0d got %0d", x.tag, matched_tag); fail_count++;
          end
          if (copy_length !== x.copy) begin
            $error("copy_length exp %0d got %0d", x.copy, copy_length); fail_count++;
          end
          if (overflow !== x.overflow) begin
            $error("overflow exp %0d got %0d", x.overflow, overflow); fail_count++;
          end
          if (matched_mode !== x.mode) begin
            $error("matched_mode exp %0d got %0d", x.mode, matched_mode); fail_count++;
          end
        end
      end
      if (start && !busy) match_request();
    end
  end
endmodule

FILE: tb/sv/tb_message_tag_matching_engine.sv
// testbench top for the message tag matching engine: stimulus and verdict
`timescale 1ns / 1ps
module tb_message_tag_matching_engine;
  logic clk = 0, rst = 1, start = 0;
  logic busy, done, overflow;
  logic command = 0, any_source = 0, any_tag = 0;
  logic [7:0] source = 0, communicator = 0, request_handle = 0;
  logic [15:0] tag = 0, length_bytes = 0;
  logic [1:0] send_mode = 0;
  logic [1:0] outcome, matched_mode;
  logic [7:0] matched_handle, matched_source;
  logic [15:0] matched_tag, copy_length;
  int fail_count, pending;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  message_tag_matching_engine u_dut (.*);
  mtm_checker u_chk (.*);

  // one command beat, held until accepted, then an idle gap of random length, sometimes none
  task automatic send_beat(logic c, logic [7:0] s, logic as, logic [15:0] t, logic at,
                           logic [7:0] cm, logic [15:0] l, logic [1:0] m, logic [7:0] h);
    int gap;
    command <= c; source <= s; any_source <= as; tag <= t; any_tag <= at;
    communicator <= cm; length_bytes <= l; send_mode <= m; request_handle <= h;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int kind;
    logic [7:0] s, cm;
    logic [15:0] t;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, wildcards, mode three, equal sizes, overflow
    send_beat(mtm_pkg::CMD_SEND, 8'hff, 1'b1, 16'hffff, 1'b1, 8'hff, 16'hffff, 2'd3, 8'hff);
    send_beat(mtm_pkg::CMD_RECV, 8'hff, 1'b0, 16'hffff, 1'b0, 8'hff, 16'hffff, 2'd0, 8'h01);
    send_beat(mtm_pkg::CMD_SEND, 8'h00, 1'b0, 16'h0, 1'b0, 8'h00, 16'd100, 2'd2, 8'h00);
    send_beat(mtm_pkg::CMD_RECV, 8'h55, 1'b1, 16'h1234, 1'b1, 8'h00, 16'd50, 2'd0, 8'h02);
    send_beat(mtm_pkg::CMD_RECV, 8'h10, 1'b1, 16'h0007, 1'b0, 8'h03, 16'd20, 2'd0, 8'h03);
    send_beat(mtm_pkg::CMD_SEND, 8'h99, 1'b0, 16'h0007, 1'b0, 8'h03, 16'd10, 2'd1, 8'h04);
    send_beat(mtm_pkg::CMD_RECV, 8'h21, 1'b0, 16'h0, 1'b1, 8'h04, 16'd0, 2'd0, 8'h05);
    send_beat(mtm_pkg::CMD_SEND, 8'h21, 1'b0, 16'haaaa, 1'b0, 8'h05, 16'd0, 2'd0, 8'h06);
    send_beat(mtm_pkg::CMD_SEND, 8'h21, 1'b0, 16'h5555, 1'b0, 8'h04, 16'd0, 2'd0, 8'h07);
    drain();
    // fill and overflow both stores
    for (int i = 0; i < 18; i++)
      send_beat(mtm_pkg::CMD_SEND, i[7:0], 1'b0, 16'h0, 1'b0, 8'h80, i[15:0], i[1:0], i[7:0]);
    for (int i = 0; i < 18; i++)
      send_beat(mtm_pkg::CMD_RECV, 8'h0, 1'b0, 16'h1, 1'b0, 8'h81, 16'h8, 2'd0, i[7:0]);
    drain();
    for (int i = 0; i < 18; i++)
      send_beat(mtm_pkg::CMD_RECV, 8'h0, 1'b1, 16'h0, 1'b1, 8'h80, 16'h3, 2'd0, i[7:0]);
    for (int i = 0; i < 18; i++)
      send_beat(mtm_pkg::CMD_SEND, 8'h0, 1'b0, 16'h1, 1'b0, 8'h81, 16'h8, 2'd0, i[7:0]);
    drain();
    // random: small value pools so matches are common, full values now and then
    for (int n = 0; n < 400; n++) begin
      kind = $urandom_range(0, 9);
      s  = (kind == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      t  = (kind == 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
      cm = (kind == 2) ? 8'($urandom) : 8'($urandom_range(0, 1));
      send_beat(1'($urandom), s, 1'($urandom), t, 1'($urandom), cm, 16'($urandom),
                2'($urandom), 8'($urandom));
      if (n == 200) drain();
    end
    drain();
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: message_tag_matching_engine.f
hdl/mtm_pkg.sv
hdl/mtm_front.sv
hdl/mtm_back.sv
hdl/message_tag_matching_engine.sv
hdl/mtm_checker.sv
tb/sv/mtm_checker.sv
tb/sv/tb_message_tag_matching_engine.sv
